@@ sv/fibonacci_matrix_block_cipher_unit_assert.svh @@
// Assertion macros for the Fibonacci matrix block cipher unit.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef FIBONACCI_MATRIX_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define FIBONACCI_MATRIX_BLOCK_CIPHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, off during reset.
`define FMBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Next-cycle implication, off during reset.
`define FMBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FMBC_ASSERT(lbl, prop, msg)
`define FMBC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/fmbc_pkg.sv @@
// Shared types and constants for the Fibonacci matrix block cipher unit.
// No dependencies.
package fmbc_pkg;

    localparam int ELEM_WIDTH = 64;               // arithmetic wraps modulo 2^ELEM_WIDTH
    localparam int LO_W       = ELEM_WIDTH / 2;   // low half of a split multiply
    localparam int HI_W       = ELEM_WIDTH - LO_W;
    localparam int FIELD_W    = 64;               // port field width
    localparam int EXP_W      = 7;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int NUM_PROD   = 10;               // eight matrix products, two for det

    typedef logic [ELEM_WIDTH-1:0]   t_elem;
    typedef logic signed [FIELD_W-1:0] t_field;

    // register indexes
    localparam logic [1:0] REG_KEY_EXP = 2'd0;
    localparam logic [1:0] REG_DECRYPT = 2'd1;
    localparam logic [1:0] REG_CHECK   = 2'd2;

    // Q = [1 1; 1 0]
    localparam t_elem Q_A = t_elem'(1);
    localparam t_elem Q_B = t_elem'(1);
    localparam t_elem Q_C = t_elem'(1);
    localparam t_elem Q_D = t_elem'(0);

    typedef struct packed {
        t_field elem_a;
        t_field elem_b;
        t_field elem_c;
        t_field elem_d;
        t_field stored_det;
    } t_in_req;

    typedef struct packed {
        t_field res_a;
        t_field res_b;
        t_field res_c;
        t_field res_d;
        t_field res_det;
        logic   det_mismatch;
    } t_res;

    function automatic t_field sext(input t_elem v);
        return FIELD_W'($signed(v));
    endfunction

endpackage

@@ sv/fmbc_mullo.sv @@
// Two-stage low-half product of two ELEM_WIDTH words, built from half-width multiplies.
// Depends on fmbc_pkg.
module fmbc_mullo import fmbc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en_pp,
    input  logic  i_en_sum,
    input  t_elem i_x,
    input  t_elem i_y,
    output t_elem o_p
);

    logic [LO_W-1:0]   w_xl, w_yl;
    logic [HI_W-1:0]   w_xh, w_yh;
    logic [2*LO_W-1:0] w_ll;
    logic [2*LO_W-1:0] r_ll;
    logic [HI_W-1:0]   r_hl, r_lh;
    t_elem             r_p;

    assign w_xl = i_x[LO_W-1:0];
    assign w_yl = i_y[LO_W-1:0];
    assign w_xh = i_x[ELEM_WIDTH-1:LO_W];
    assign w_yh = i_y[ELEM_WIDTH-1:LO_W];
    assign w_ll = w_xl * w_yl;

    // partial products; cross terms only need their low HI_W bits
    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= w_ll;
            r_hl <= HI_W'(w_xh * w_yl);
            r_lh <= HI_W'(w_xl * w_yh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= ELEM_WIDTH'(r_ll) + {HI_W'(r_hl + r_lh), LO_W'(0)};
        end
    end

    assign o_p = r_p;

endmodule

@@ sv/fibonacci_matrix_block_cipher_unit.sv @@
// Fibonacci Q-matrix block cipher: key = Q^n, encrypt K*P (+det), decrypt (+-adj K)*C.
// Requests pass partial-product, sum, element-sum and output registers; one is taken
// per cycle unless the result side stalls. Writing key_exponent rebuilds the key, one
// add step per cycle, then the inverse key, accepting no request meanwhile. Reset (sync,
// active low) loads Q, n = 1, encrypt, checking off, and forms the inverse key first.
`include "fibonacci_matrix_block_cipher_unit_assert.svh"
module fibonacci_matrix_block_cipher_unit import fmbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  t_in_req            i_in,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    // result channel
    output t_res               o_res,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // key builder states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_BUILD  = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    // per-request control that rides along the pipe
    typedef struct packed {
        logic  decrypt;
        logic  check;
        logic  neg;
        t_elem sdet;
    } t_ctrl;

    //--------------------------------------------------------------------
    // Configuration registers
    //--------------------------------------------------------------------
    logic [1:0]       w_idx;
    logic             w_cfg_wr;
    logic             w_cfg_exp;
    logic [EXP_W-1:0] w_exp;
    logic [EXP_W-1:0] w_n;

    logic [EXP_W-1:0] r_key_exp;
    logic             r_decrypt;
    logic             r_check;

    assign pready    = 1'b1;
    assign w_idx     = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_exp = w_cfg_wr && (w_idx == REG_KEY_EXP);
    assign w_exp     = pwdata[EXP_W-1:0];
    // exponent zero builds Q itself
    assign w_n       = (w_exp == '0) ? EXP_W'(1) : w_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_exp <= EXP_W'(1);
            r_decrypt <= 1'b0;
            r_check   <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_KEY_EXP: r_key_exp <= w_exp;
                REG_DECRYPT: r_decrypt <= pwdata[0];
                REG_CHECK:   r_check   <= pwdata[0];
                default: ;  // beyond the register list: ignored
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KEY_EXP: prdata = PDATA_W'(r_key_exp);
            REG_DECRYPT: prdata = PDATA_W'(r_decrypt);
            REG_CHECK:   prdata = PDATA_W'(r_check);
            default:     prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------
    // Key builder. Right-multiplying by Q is only adds:
    // [a b; c d] * Q = [a+b a; c+d c]. FINISH forms the decrypt operand
    // det(K)*adj(K), det(K) = -1 for odd n.
    //--------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [EXP_W-1:0] r_cnt, n_cnt;
    logic             r_det_neg, n_det_neg;
    t_elem            r_key [4];
    t_elem            n_key [4];
    t_elem            r_inv [4];

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_det_neg = r_det_neg;
        n_key     = r_key;
        if (w_cfg_exp) begin
            n_key     = '{Q_A, Q_B, Q_C, Q_D};
            n_cnt     = EXP_W'(w_n - EXP_W'(1));
            n_det_neg = w_n[0];
            n_state   = (w_n == EXP_W'(1)) ? ST_FINISH : ST_BUILD;
        end else begin
            case (r_state)
                ST_BUILD: begin
                    n_key[0] = r_key[0] + r_key[1];
                    n_key[1] = r_key[0];
                    n_key[2] = r_key[2] + r_key[3];
                    n_key[3] = r_key[2];
                    n_cnt    = r_cnt - EXP_W'(1);
                    if (r_cnt == EXP_W'(1)) begin
                        n_state = ST_FINISH;
                    end
                end
                ST_FINISH: n_state = ST_IDLE;
                ST_IDLE:   n_state = ST_IDLE;
                default:   n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FINISH;
            r_cnt     <= '0;
            r_det_neg <= 1'b1;
            r_key     <= '{Q_A, Q_B, Q_C, Q_D};
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_det_neg <= n_det_neg;
            r_key     <= n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            if (r_det_neg) begin
                r_inv[0] <= t_elem'(0) - r_key[3];
                r_inv[1] <= r_key[1];
                r_inv[2] <= r_key[2];
                r_inv[3] <= t_elem'(0) - r_key[0];
            end else begin
                r_inv[0] <= r_key[3];
                r_inv[1] <= t_elem'(0) - r_key[1];
                r_inv[2] <= t_elem'(0) - r_key[2];
                r_inv[3] <= r_key[0];
            end
        end
    end

    //--------------------------------------------------------------------
    // Pipeline flow: each stage moves when its successor is empty or
    // moving, so bubbles close up behind a stalled result.
    //--------------------------------------------------------------------
    logic  r_v1, r_v2, r_v3, r_v4;
    logic  w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic  w_acc;
    t_ctrl w_ctrl;
    t_ctrl r_c1, r_c2, r_c3;

    assign w_rdy4     = !r_v4 || !i_res_stall;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1 || (r_state != ST_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;

    assign w_ctrl.decrypt = r_decrypt;
    assign w_ctrl.check   = r_check;
    assign w_ctrl.neg     = r_det_neg;
    assign w_ctrl.sdet    = i_in.stored_det[ELEM_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_acc;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_c1 <= w_ctrl;
        if (w_rdy2) r_c2 <= r_c1;
        if (w_rdy3) r_c3 <= r_c2;
    end

    //--------------------------------------------------------------------
    // Stages 1-2: eight products M*B (M = key or inverse key) plus the two
    // for det(B). Each is split into partial products, then summed.
    //--------------------------------------------------------------------
    t_elem w_m [4];
    t_elem w_b [4];
    t_elem w_x [NUM_PROD];
    t_elem w_y [NUM_PROD];
    t_elem w_p [NUM_PROD];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_m[i] = r_decrypt ? r_inv[i] : r_key[i];
        end
    end

    assign w_b[0] = i_in.elem_a[ELEM_WIDTH-1:0];
    assign w_b[1] = i_in.elem_b[ELEM_WIDTH-1:0];
    assign w_b[2] = i_in.elem_c[ELEM_WIDTH-1:0];
    assign w_b[3] = i_in.elem_d[ELEM_WIDTH-1:0];

    // res[i][j] = m[i][0]*b[0][j] + m[i][1]*b[1][j]
    assign w_x = '{w_m[0], w_m[1], w_m[0], w_m[1], w_m[2], w_m[3], w_m[2], w_m[3],
                   w_b[0], w_b[1]};
    assign w_y = '{w_b[0], w_b[2], w_b[1], w_b[3], w_b[0], w_b[2], w_b[1], w_b[3],
                   w_b[3], w_b[2]};

    for (genvar g = 0; g < NUM_PROD; g++) begin : g_mul
        fmbc_mullo u_mul (
            .i_clk    (i_clk),
            .i_en_pp  (w_rdy1),
            .i_en_sum (w_rdy2),
            .i_x      (w_x[g]),
            .i_y      (w_y[g]),
            .o_p      (w_p[g])
        );
    end

    //--------------------------------------------------------------------
    // Stage 3: element sums and det(B)
    //--------------------------------------------------------------------
    t_elem r_sum [4];
    t_elem r_dp;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= w_p[2*k] + w_p[2*k+1];
            end
            r_dp <= w_p[8] - w_p[9];
        end
    end

    //--------------------------------------------------------------------
    // Stage 4: output register. det(K*P) = det(K)*det(P) = +-det(P).
    //--------------------------------------------------------------------
    t_elem w_det_enc;
    t_res  r_out;

    assign w_det_enc = r_c3.neg ? (t_elem'(0) - r_dp) : r_dp;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_out.res_a        <= sext(r_sum[0]);
            r_out.res_b        <= sext(r_sum[1]);
            r_out.res_c        <= sext(r_sum[2]);
            r_out.res_d        <= sext(r_sum[3]);
            r_out.res_det      <= r_c3.decrypt ? '0 : sext(w_det_enc);
            r_out.det_mismatch <= r_c3.decrypt && r_c3.check && (r_dp != r_c3.sdet);
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_v4;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    `FMBC_ASSERT(a_busy_stalls, (r_state != ST_IDLE) |-> o_in_stall, "request during key build")
    `FMBC_ASSERT(a_build_cnt, (r_state == ST_BUILD) |-> (r_cnt != '0), "build count underflow")
    `FMBC_ASSERT(a_mis_dec,
                 (o_res_valid && o_res.det_mismatch) |-> (o_res.res_det == '0),
                 "mismatch outside decrypt")
    `FMBC_ASSERT_NEXT(a_finish_idle, (r_state == ST_FINISH) && !w_cfg_exp,
                      r_state == ST_IDLE, "finish did not return to idle")

endmodule

@@ tb/sv/fibonacci_matrix_block_cipher_unit_checker.sv @@
// Checker for the Fibonacci matrix block cipher unit: tracks the register writes,
// predicts each block's result and compares it with what leaves the block.
// Depends on fmbc_pkg.
module fibonacci_matrix_block_cipher_unit_checker import fmbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_req            i_req,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  t_res               i_res,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_blocks_due
);

    // [0]=a [1]=b [2]=c [3]=d, row-major
    typedef logic [3:0][ELEM_WIDTH-1:0] mat2_t;
    localparam mat2_t FIB_Q = {Q_D, Q_C, Q_B, Q_A};

    mat2_t key_mat;
    logic  key_odd;
    logic  decrypting;
    logic  checking;
    t_res  cipher_due[$];
    t_res  want;
    int    fails = 0;

    function automatic mat2_t mat_mul(input mat2_t x, input mat2_t y);
        mat2_t r;
        r[0] = x[0] * y[0] + x[1] * y[2];
        r[1] = x[0] * y[1] + x[1] * y[3];
        r[2] = x[2] * y[0] + x[3] * y[2];
        r[3] = x[2] * y[1] + x[3] * y[3];
        return r;
    endfunction

    function automatic t_elem mat_det(input mat2_t m);
        return m[0] * m[3] - m[1] * m[2];
    endfunction

    // key = Q^n, an exponent of zero counts as one
    task automatic load_exponent(input logic [EXP_W-1:0] n);
        int steps;
        steps   = (n == 0) ? 1 : int'(n);
        key_mat = FIB_Q;
        for (int k = 1; k < steps; k++)
            key_mat = mat_mul(key_mat, FIB_Q);
        key_odd = steps[0];
    endtask

    function automatic t_res cipher_block(input t_in_req r);
        mat2_t blk;
        mat2_t inv;
        mat2_t prod;
        t_res  out;
        blk = {t_elem'(r.elem_d), t_elem'(r.elem_c), t_elem'(r.elem_b), t_elem'(r.elem_a)};
        out = '0;
        if (decrypting) begin
            // adjugate, negated when det(K) = -1
            inv = {key_mat[0], -key_mat[2], -key_mat[1], key_mat[3]};
            if (key_odd)
                for (int i = 0; i < 4; i++)
                    inv[i] = -inv[i];
            prod = mat_mul(inv, blk);
            out.det_mismatch = checking && (mat_det(blk) != t_elem'(r.stored_det));
        end else begin
            prod = mat_mul(key_mat, blk);
            out.res_det = t_field'($signed(mat_det(prod)));
        end
        out.res_a = t_field'($signed(prod[0]));
        out.res_b = t_field'($signed(prod[1]));
        out.res_c = t_field'($signed(prod[2]));
        out.res_d = t_field'($signed(prod[3]));
        return out;
    endfunction

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want_v,
                               input logic [FIELD_W-1:0] got_v);
        if (got_v !== want_v) begin
            fails++;
            $error("%s: expected %h, got %h", name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            decrypting = 1'b0;
            checking   = 1'b0;
            load_exponent(EXP_W'(1));
            cipher_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    {REG_KEY_EXP, 2'b00}: load_exponent(i_pwdata[EXP_W-1:0]);
                    {REG_DECRYPT, 2'b00}: decrypting = i_pwdata[0];
                    {REG_CHECK, 2'b00}:   checking = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall)
                cipher_due.push_back(cipher_block(i_req));
            if (i_res_valid && !i_res_stall) begin
                if (cipher_due.size() == 0) begin
                    fails++;
                    $error("result with no request outstanding");
                end else begin
                    want = cipher_due.pop_front();
                    check_field("res_a", want.res_a, i_res.res_a);
                    check_field("res_b", want.res_b, i_res.res_b);
                    check_field("res_c", want.res_c, i_res.res_c);
                    check_field("res_d", want.res_d, i_res.res_d);
                    check_field("res_det", want.res_det, i_res.res_det);
                    check_field("det_mismatch", FIELD_W'(want.det_mismatch),
                                FIELD_W'(i_res.det_mismatch));
                end
            end
        end
        o_fail_count <= fails;
        o_blocks_due <= cipher_due.size();
    end

endmodule

@@ tb/sv/fibonacci_matrix_block_cipher_unit_tb.sv @@
// Testbench top for the Fibonacci matrix block cipher unit: drives requests,
// stalls results and writes the registers; the checker module does the comparing.
// Depends on fmbc_pkg, the unit and fibonacci_matrix_block_cipher_unit_checker.
module fibonacci_matrix_block_cipher_unit_tb;
    import fmbc_pkg::*;

    localparam int         CYCLE_LIMIT = 600000;
    localparam int         HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int         PHASES      = 12;
    localparam int         PHASE_ITEMS = 153;
    localparam logic [1:0] REG_UNUSED  = 2'd3;  // address past the last register
    localparam t_field     ELEM_MIN    = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam t_field     ELEM_MAX    = ~ELEM_MIN;

    logic               i_clk;
    logic               i_rst_n;
    t_in_req            i_in;
    logic               i_in_valid;
    logic               o_in_stall;
    t_res               o_res;
    logic               o_res_valid;
    logic               i_res_stall;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int blocks_due;
    int cycle_count = 0;
    bit quiet        = 1'b0;   // no idling on either side
    bit hold_off_req = 1'b0;   // ask the result side for one long stall
    bit cur_dec      = 1'b0;   // decrypt mode as last written

    fibonacci_matrix_block_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    fibonacci_matrix_block_cipher_unit_checker cipher_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_in),
        .i_req_valid  (i_in_valid),
        .i_req_stall  (o_in_stall),
        .i_res        (o_res),
        .i_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_blocks_due (blocks_due)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Element values biased toward the corners: zero, -1, both extremes, small
    // magnitudes of either sign, otherwise a full random word.
    function automatic t_field rand_elem();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ELEM_MIN;
            3:       return ELEM_MAX;
            4:       return t_field'($urandom_range(0, 15));
            5:       return -t_field'($urandom_range(1, 16));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_req make_block(input t_field a, input t_field b, input t_field c,
                                           input t_field d, input t_field s);
        t_in_req r;
        r.elem_a     = a;
        r.elem_b     = b;
        r.elem_c     = c;
        r.elem_d     = d;
        r.stored_det = s;
        return r;
    endfunction

    // Determinant carried with a well-formed cipher block.
    function automatic t_field block_det(input t_in_req r);
        t_elem p;
        p = t_elem'(r.elem_a) * t_elem'(r.elem_d) - t_elem'(r.elem_b) * t_elem'(r.elem_c);
        return t_field'($signed(p));
    endfunction

    // Offer one request, hold it until taken, then idle for a random gap.
    // With a zero gap valid stays high for the next request.
    task automatic send_block(input t_in_req r);
        int gap;
        i_in       <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every request has come back, plus the
    // pipeline depth so the block is truly idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (blocks_due != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // Setup phase, access phase held until pready, then idle before the next write.
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper bits of each write are random; the unit keeps only the register width.
    // The exponent goes last since it starts the key rebuild.
    task automatic set_mode(input int n, input bit dec, input bit chk);
        drain();
        write_reg(REG_DECRYPT, ($urandom & ~32'h1) | PDATA_W'(dec));
        write_reg(REG_CHECK, ($urandom & ~32'h1) | PDATA_W'(chk));
        write_reg(REG_KEY_EXP, ($urandom & ~32'h7f) | PDATA_W'(n));
        cur_dec = dec;
    endtask

    // Result side: a random stall before each result, none while quiet, and
    // one long hold-off when asked, so the block backs up into its input.
    initial begin : result_sink
        int w;
        i_res_stall = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                w = HOLD_CYCLES;
            end else if (quiet) begin
                w = 0;
            end else begin
                w = $urandom_range(0, 19);
            end
            if (w > 0) begin
                i_res_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (o_res_valid !== 1'b1);
        end
    end

    initial begin : stimulus
        t_in_req req;
        i_rst_n    = 1'b0;
        i_in       = '0;
        i_in_valid = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state first (key Q, encrypt), field extremes.
        send_block(make_block('0, '0, '0, '0, '0));
        send_block(make_block('1, '1, '1, '1, rand_elem()));
        send_block(make_block(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_block(make_block(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_block(make_block(t_field'(1), '0, '0, t_field'(1), '0));
        send_block(make_block(ELEM_MAX, ELEM_MIN, '1, t_field'(1), rand_elem()));

        // Write past the last register: nothing may change.
        drain();
        write_reg(REG_UNUSED, $urandom);
        send_block(make_block(t_field'(1), t_field'(2), t_field'(3), t_field'(4), '0));

        // Decrypt with checking, power one: Q itself decrypts to identity, det -1.
        set_mode(1, 1'b1, 1'b1);
        send_block(make_block(t_field'(1), t_field'(1), t_field'(1), '0, '1));
        send_block(make_block(t_field'(1), t_field'(1), t_field'(1), '0, '0));
        req = make_block(ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MIN, '0);
        req.stored_det = block_det(req);
        send_block(req);
        send_block(make_block(ELEM_MAX, '1, ELEM_MIN, t_field'(1), rand_elem()));

        // Checking off: a wrong determinant goes unflagged.
        set_mode(1, 1'b1, 1'b0);
        send_block(make_block(t_field'(5), t_field'(7), ELEM_MIN, '1, t_field'(3)));

        // Exponent zero acts as one.
        set_mode(0, 1'b0, 1'b0);
        send_block(make_block(t_field'(2), t_field'(3), t_field'(5), t_field'(8), '0));
        send_block(make_block(ELEM_MAX, '1, '1, ELEM_MIN, '0));

        // Largest power that fits, both directions.
        set_mode(91, 1'b0, 1'b0);
        send_block(make_block(t_field'(1), '0, '0, t_field'(1), '0));
        send_block(make_block(rand_elem(), rand_elem(), rand_elem(), rand_elem(), '0));
        set_mode(91, 1'b1, 1'b1);
        req = make_block(rand_elem(), rand_elem(), rand_elem(), rand_elem(), '0);
        req.stored_det = block_det(req);
        send_block(req);
        send_block(make_block(t_field'(1), t_field'(1), t_field'(1), '0, t_field'(1)));

        // Beyond 91 the key wraps; checking on while encrypting flags nothing.
        set_mode(127, 1'b0, 1'b1);
        send_block(make_block(t_field'(1), '0, '0, t_field'(1), t_field'(9)));
        send_block(make_block(ELEM_MIN, ELEM_MAX, '1, '0, rand_elem()));

        // Random phases. Most decrypt blocks carry their true determinant so the
        // check passes; the rest carry noise. Phase 2 backs the block up with a
        // long result hold-off, phase 4 drains halfway through.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       set_mode(91, 1'b0, 1'b0);
                1:       set_mode(2, 1'b1, 1'b1);
                2:       set_mode(127, 1'b1, 1'b1);
                3:       set_mode(0, 1'b0, 1'b0);
                4:       set_mode(1, 1'b1, 1'b0);
                5:       set_mode(91, 1'b1, 1'b1);
                default: set_mode($urandom_range(0, 127), $urandom_range(0, 1),
                                  $urandom_range(0, 1));
            endcase
            quiet        = (p == 2 || p == 3 || p == 8);
            hold_off_req = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                req = make_block(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                                 rand_elem());
                if (cur_dec && $urandom_range(0, 4) != 0)
                    req.stored_det = block_det(req);
                send_block(req);
                if (p == 4 && i == PHASE_ITEMS / 2)
                    drain();
            end
            quiet = 1'b0;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && blocks_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
